FILE: src/gtdc_pkg.sv
// ----------------------------------------------------------------------------
// gtdc_pkg: shared types and constants of the 6x8 text renderer
// Item types of both channels, the cursor word, controller command codes,
// sequencing steps and the 6x8 font table.
// ----------------------------------------------------------------------------
`default_nettype none

package gtdc_pkg;

  // One character to draw, with an optional cursor reload.
  typedef struct packed {
    logic [7:0] char_code;
    logic       restart;
    logic [7:0] start_column;
    logic [2:0] start_page;
  } char_item_t;

  // One byte for the display controller.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } cmd_item_t;

  // Text cursor as held in the cursor memory.
  typedef struct packed {
    logic [7:0] column;
    logic [2:0] page;
  } cursor_t;

  localparam int CursorBits = $bits(cursor_t);
  localparam int GlyphBits  = 48;

  localparam logic [7:0] WrapColumn = 8'd126;
  localparam logic [7:0] GlyphWidth = 8'd6;
  localparam logic [7:0] FontFirst  = 8'd32;

  localparam logic [7:0] PageCmd  = 8'hB0;
  localparam logic [7:0] ColHiCmd = 8'h10;
  localparam logic [7:0] ColLoSet = 8'h01;

  // Byte positions within the nine bytes of one character.
  localparam logic [3:0] StepPage  = 4'd0;
  localparam logic [3:0] StepColHi = 4'd1;
  localparam logic [3:0] StepColLo = 4'd2;
  localparam logic [3:0] StepData  = 4'd3;
  localparam logic [3:0] StepLast  = 4'd8;

  // Glyph columns of one character, column 0 in the top byte.
  function automatic logic [GlyphBits-1:0] glyph_row(input logic [6:0] idx);
    logic [GlyphBits-1:0] row;
    case (idx)
      7'd0:  row = 48'h000000000000;
      7'd1:  row = 48'h0000002f0000;
      7'd2:  row = 48'h000007000700;
      7'd3:  row = 48'h00147f147f14;
      7'd4:  row = 48'h00242a7f2a12;
      7'd5:  row = 48'h006264081323;
      7'd6:  row = 48'h003649552250;
      7'd7:  row = 48'h000005030000;
      7'd8:  row = 48'h00001c224100;
      7'd9:  row = 48'h000041221c00;
      7'd10: row = 48'h0014083e0814;
      7'd11: row = 48'h0008083e0808;
      7'd12: row = 48'h000000a06000;
      7'd13: row = 48'h000808080808;
      7'd14: row = 48'h000060600000;
      7'd15: row = 48'h002010080402;
      7'd16: row = 48'h003e5149453e;
      7'd17: row = 48'h0000427f4000;
      7'd18: row = 48'h004261514946;
      7'd19: row = 48'h002141454b31;
      7'd20: row = 48'h001814127f10;
      7'd21: row = 48'h002745454539;
      7'd22: row = 48'h003c4a494930;
      7'd23: row = 48'h000171090503;
      7'd24: row = 48'h003649494936;
      7'd25: row = 48'h00064949291e;
      7'd26: row = 48'h000036360000;
      7'd27: row = 48'h000056360000;
      7'd28: row = 48'h000814224100;
      7'd29: row = 48'h001414141414;
      7'd30: row = 48'h000041221408;
      7'd31: row = 48'h000201510906;
      7'd32: row = 48'h00324959513e;
      7'd33: row = 48'h007c1211127c;
      7'd34: row = 48'h007f49494936;
      7'd35: row = 48'h003e41414122;
      7'd36: row = 48'h007f4141221c;
      7'd37: row = 48'h007f49494941;
      7'd38: row = 48'h007f09090901;
      7'd39: row = 48'h003e4149497a;
      7'd40: row = 48'h007f0808087f;
      7'd41: row = 48'h0000417f4100;
      7'd42: row = 48'h002040413f01;
      7'd43: row = 48'h007f08142241;
      7'd44: row = 48'h007f40404040;
      7'd45: row = 48'h007f020c027f;
      7'd46: row = 48'h007f0408107f;
      7'd47: row = 48'h003e4141413e;
      7'd48: row = 48'h007f09090906;
      7'd49: row = 48'h003e4151215e;
      7'd50: row = 48'h007f09192946;
      7'd51: row = 48'h004649494931;
      7'd52: row = 48'h0001017f0101;
      7'd53: row = 48'h003f4040403f;
      7'd54: row = 48'h001f2040201f;
      7'd55: row = 48'h003f4038403f;
      7'd56: row = 48'h006314081463;
      7'd57: row = 48'h000708700807;
      7'd58: row = 48'h006151494543;
      7'd59: row = 48'h00007f414100;
      7'd60: row = 48'h00552a552a55;
      7'd61: row = 48'h000041417f00;
      7'd62: row = 48'h000402010204;
      7'd63: row = 48'h004040404040;
      7'd64: row = 48'h000001020400;
      7'd65: row = 48'h002054545478;
      7'd66: row = 48'h007f48444438;
      7'd67: row = 48'h003844444420;
      7'd68: row = 48'h00384444487f;
      7'd69: row = 48'h003854545418;
      7'd70: row = 48'h00087e090102;
      7'd71: row = 48'h0018a4a4a47c;
      7'd72: row = 48'h007f08040478;
      7'd73: row = 48'h0000447d4000;
      7'd74: row = 48'h004080847d00;
      7'd75: row = 48'h007f10284400;
      7'd76: row = 48'h0000417f4000;
      7'd77: row = 48'h007c04180478;
      7'd78: row = 48'h007c08040478;
      7'd79: row = 48'h003844444438;
      7'd80: row = 48'h00fc24242418;
      7'd81: row = 48'h0018242418fc;
      7'd82: row = 48'h007c08040408;
      7'd83: row = 48'h004854545420;
      7'd84: row = 48'h00043f444020;
      7'd85: row = 48'h003c4040207c;
      7'd86: row = 48'h001c2040201c;
      7'd87: row = 48'h003c4030403c;
      7'd88: row = 48'h004428102844;
      7'd89: row = 48'h001ca0a0a07c;
      7'd90: row = 48'h004464544c44;
      7'd91: row = 48'h141414141414;
      // The last four codes of the font and all unused indexes are blank.
      default: row = 48'h000000000000;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

FILE: src/glyph_text_stream_to_display_cmds_core.sv
// ----------------------------------------------------------------------------
// glyph_text_stream_to_display_cmds_core: 6x8 text renderer for an OLED
// Turns each character into three position commands and six glyph columns,
// keeping the text cursor in a small memory that is read, updated and
// written back once per character.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | item
//   char    | in        | char_valid/char_stall  | gtdc_pkg::char_item_t
//   cmd     | out       | cmd_valid/cmd_stall    | gtdc_pkg::cmd_item_t
//
// Each character gives nine bytes, one per cycle while the output does not
// stall, so the byte sequencer sets the pace at which characters are taken.
// On its way out, a character passes the cursor memory read, the cursor
// update and the output register.
// A character waits in the cursor stage while the previous one is still being
// sent; a stalled output holds its byte and stops the sequencer.
// Reset is synchronous; the cursor reads as column 0, page 0 until written.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_stream_to_display_cmds_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 char_valid,
  output logic                      char_stall,
  input  wire gtdc_pkg::char_item_t char_item,
  output logic                      cmd_valid,
  input  wire logic                 cmd_stall,
  output gtdc_pkg::cmd_item_t       cmd_item
);

  // Cursor stage: character waiting for the cursor memory read.
  logic                 s1_valid;
  gtdc_pkg::char_item_t s1_item;

  // Sequencer stage: position and glyph of the character being sent.
  logic                              s2_valid;
  logic [7:0]                        s2_column;
  logic [2:0]                        s2_page;
  logic [gtdc_pkg::GlyphBits-1:0]    s2_glyph;
  logic [3:0]                        s2_step;

  logic                 char_accept;
  logic                 out_load;
  logic                 s2_done;
  logic                 s1_move;

  logic                 cur_written;
  logic                 fwd_valid;
  gtdc_pkg::cursor_t    fwd_cursor;
  gtdc_pkg::cursor_t    ram_rdata;
  gtdc_pkg::cursor_t    cur_stored;
  gtdc_pkg::cursor_t    cursor_next;

  logic [7:0]           base_column;
  logic [2:0]           base_page;
  logic                 wrap;
  logic [7:0]           draw_column;
  logic [2:0]           draw_page;
  logic                 in_font;
  logic [6:0]           glyph_idx;
  logic [gtdc_pkg::GlyphBits-1:0] glyph_sel;

  gtdc_pkg::cmd_item_t  byte_next;

  assign char_accept = char_valid && !char_stall;
  assign out_load    = s2_valid && (!cmd_valid || !cmd_stall);
  assign s2_done     = out_load && (s2_step == gtdc_pkg::StepLast);
  assign s1_move     = s1_valid && (!s2_valid || s2_done);
  assign char_stall  = s1_valid && !s1_move;

  gtdc_ram #(
    .WIDTH (gtdc_pkg::CursorBits),
    .DEPTH (1)
  ) u_cursor_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (1'b0),
    .wdata (cursor_next),
    .re    (char_accept),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  // A read issued in the same cycle as the write-back sees the old word,
  // so the written cursor is forwarded instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid   <= 1'b0;
      cur_written <= 1'b0;
    end else begin
      if (char_accept) begin
        fwd_valid <= s1_move;
      end
      if (s1_move) begin
        cur_written <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_accept) begin
      fwd_cursor <= cursor_next;
    end
  end

  always_comb begin
    if (fwd_valid) begin
      cur_stored = fwd_cursor;
    end else if (cur_written) begin
      cur_stored = ram_rdata;
    end else begin
      cur_stored = '0;
    end
  end

  // Cursor update and font lookup for the character in the cursor stage.
  always_comb begin
    base_column = s1_item.restart ? s1_item.start_column : cur_stored.column;
    base_page   = s1_item.restart ? s1_item.start_page   : cur_stored.page;
    wrap        = base_column > gtdc_pkg::WrapColumn;
    draw_column = wrap ? 8'd0 : base_column;
    draw_page   = wrap ? base_page + 3'd1 : base_page;
    cursor_next.column = draw_column + gtdc_pkg::GlyphWidth;
    cursor_next.page   = draw_page;

    in_font   = (s1_item.char_code >= gtdc_pkg::FontFirst) && !s1_item.char_code[7];
    glyph_idx = 7'(s1_item.char_code - gtdc_pkg::FontFirst);
    glyph_sel = in_font ? gtdc_pkg::glyph_row(glyph_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_accept) begin
      s1_item <= char_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_step  <= gtdc_pkg::StepPage;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
      s2_step  <= gtdc_pkg::StepPage;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end else if (out_load) begin
      s2_step <= s2_step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_column <= draw_column;
      s2_page   <= draw_page;
      s2_glyph  <= glyph_sel;
    end else if (out_load && (s2_step >= gtdc_pkg::StepData)) begin
      s2_glyph <= {s2_glyph[gtdc_pkg::GlyphBits-9:0], 8'h00};
    end
  end

  always_comb begin
    case (s2_step)
      gtdc_pkg::StepPage:  byte_next.out_byte = gtdc_pkg::PageCmd | {5'd0, s2_page};
      gtdc_pkg::StepColHi: byte_next.out_byte = gtdc_pkg::ColHiCmd | {4'd0, s2_column[7:4]};
      gtdc_pkg::StepColLo: byte_next.out_byte = {4'd0, s2_column[3:0]} | gtdc_pkg::ColLoSet;
      default:             byte_next.out_byte = s2_glyph[gtdc_pkg::GlyphBits-1 -: 8];
    endcase
    byte_next.is_data = s2_step >= gtdc_pkg::StepData;
    byte_next.last    = s2_step == gtdc_pkg::StepLast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (out_load) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cmd_item <= byte_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/gtdc_ram.sv
// ----------------------------------------------------------------------------
// gtdc_ram: generic single-clock RAM with a registered read
// One write port and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gtdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/gtdc_checker.sv
// ----------------------------------------------------------------------------
// gtdc_checker: port-level checks of the 6x8 text renderer
// Tracks the byte position within each character on the output channel and
// checks the byte kinds against it.
// ----------------------------------------------------------------------------
`default_nettype none

module gtdc_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 char_valid,
  input wire logic                 char_stall,
  input wire gtdc_pkg::char_item_t char_item,
  input wire logic                 cmd_valid,
  input wire logic                 cmd_stall,
  input wire gtdc_pkg::cmd_item_t  cmd_item
);

  logic [3:0] pos;
  logic       cmd_accept;

  assign cmd_accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= gtdc_pkg::StepPage;
    end else if (cmd_accept) begin
      pos <= (pos == gtdc_pkg::StepLast) ? gtdc_pkg::StepPage : pos + 4'd1;
    end
  end

  // A stalled byte stays offered and unchanged.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_item))
    else $error("stalled command byte changed or was withdrawn");

  // A stalled character stays offered and unchanged.
  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_item))
    else $error("stalled character changed or was withdrawn");

  // Every character starts with a page command.
  a_page_first: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (pos == gtdc_pkg::StepPage) |->
      (cmd_item.out_byte[7:3] == gtdc_pkg::PageCmd[7:3]) && !cmd_item.is_data)
    else $error("character does not open with a page command");

  // Commands come first, then glyph data.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd_item.is_data == (pos >= gtdc_pkg::StepData))
    else $error("command and data bytes out of order");

  // The end mark falls on the ninth byte only.
  a_last: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd_item.last == (pos == gtdc_pkg::StepLast))
    else $error("end mark not on the ninth byte");

endmodule

bind glyph_text_stream_to_display_cmds_core gtdc_checker u_gtdc_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_item  (char_item),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .cmd_item   (cmd_item)
);

`default_nettype wire
